@@ rtl/sbst_pkg.sv @@
// ----------------------------------------------------------------------------
// sbst_pkg
// Shared types, constants and helpers for the second-best spanning tree unit.
// ----------------------------------------------------------------------------
package sbst_pkg;

  localparam int MaxVertices = 32;
  localparam int VertBits    = $clog2(MaxVertices);
  localparam int CntBits     = VertBits + 1;
  localparam int WeightBits  = 20;
  localparam int KeyBits     = WeightBits + 1;
  localparam int CostBits    = 25;
  localparam int AddrBits    = 2 * VertBits;
  localparam int MemDepth    = MaxVertices * MaxVertices;
  localparam int CfgBits     = 6;
  localparam int CfgIdxBits  = 1;

  localparam logic [CfgIdxBits-1:0] CfgVertexCount = 1'd0;
  localparam logic [CfgIdxBits-1:0] CfgRootVertex  = 1'd1;

  localparam logic [KeyBits-1:0] KeyInf = {KeyBits{1'b1}};

  typedef logic [WeightBits-1:0] weight_t;
  typedef logic [CostBits-1:0]   cost_t;

  typedef struct packed {
    weight_t edge_weight;
  } in_item_t;

  typedef struct packed {
    cost_t second_cost;
    logic  no_alternative;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_SEL,
    ST_JOIN,
    ST_JWAIT,
    ST_PM_RD,
    ST_PM_WR,
    ST_UPD_RD,
    ST_UPD_CMP,
    ST_PAIR_ROW,
    ST_PAIR_RD,
    ST_PAIR_CMP,
    ST_FINISH
  } state_e;

  // Address of an unordered vertex pair; only the upper triangle is stored.
  function automatic logic [AddrBits-1:0] pair_addr(input logic [VertBits-1:0] a,
                                                    input logic [VertBits-1:0] b);
    pair_addr = (a < b) ? {a, b} : {b, a};
  endfunction

endpackage

@@ rtl/sbst_in_if.sv @@
// ----------------------------------------------------------------------------
// sbst_in_if
// Valid/ready channel carrying one edge weight per request.
// ----------------------------------------------------------------------------
interface sbst_in_if;
  logic                 valid;
  logic                 ready;
  sbst_pkg::weight_t    edge_weight;

  modport source (output valid, output edge_weight, input ready);
  modport sink   (input valid, input edge_weight, output ready);
endinterface

@@ rtl/sbst_out_if.sv @@
// ----------------------------------------------------------------------------
// sbst_out_if
// Valid/ready channel carrying the second-best tree cost result.
// ----------------------------------------------------------------------------
interface sbst_out_if;
  logic                 valid;
  logic                 ready;
  sbst_pkg::cost_t      second_cost;
  logic                 no_alternative;

  modport source (output valid, output second_cost, output no_alternative, input ready);
  modport sink   (input valid, input second_cost, input no_alternative, output ready);
endinterface

@@ rtl/second_best_spanning_tree_cost_unit.sv @@
// Loading: one weight request per cycle, n*(n-1)/2 requests per graph.
// After the last weight the unit grows the tree: each Prim step scans the keys,
// fills path maxima for the tree vertices through the path-max RAM and relaxes
// keys through the weight RAM; then a pair scan checks every non-tree edge.
// Then one result is registered; the next graph may load while it waits.
// Reset (asynchronous, active low): vertex_count 2, root 0, load position (0,1).
// ----------------------------------------------------------------------------
// second_best_spanning_tree_cost_unit
// Loads a complete graph, grows a Prim tree and reports the second-best cost.
// ----------------------------------------------------------------------------
module second_best_spanning_tree_cost_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sbst_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [sbst_pkg::CfgBits-1:0]         cfg_data_i,
  sbst_in_if.sink                              in_i,
  sbst_out_if.source                           out_o
);

  localparam int VB = sbst_pkg::VertBits;
  localparam int CB = sbst_pkg::CntBits;
  localparam int WB = sbst_pkg::WeightBits;
  localparam int KB = sbst_pkg::KeyBits;
  localparam int NB = sbst_pkg::CostBits;
  localparam int AB = sbst_pkg::AddrBits;
  localparam int MV = sbst_pkg::MaxVertices;

  sbst_pkg::state_e state_q, state_d;

  logic [CB-1:0] vcount_q;
  logic [VB-1:0] root_q;
  logic [CB-1:0] row_q, col_q;

  logic [KB-1:0] key_q    [MV];
  logic [VB-1:0] parent_q [MV];
  logic [VB-1:0] order_q  [MV];
  logic [MV-1:0] in_tree_q;

  logic [CB-1:0] idx_q, joined_q, k_q, i_q, j_q;
  logic [VB-1:0] v_q, p_q, u_q, pi_q;
  logic [KB-1:0] bestk_q;
  logic          found_q;
  logic [WB-1:0] w_q, best_q;
  logic          bfound_q, tree_q;
  logic [NB-1:0] cost_q;

  logic          out_valid_q;
  logic [NB-1:0] out_cost_q;
  logic          out_noalt_q;

  // effective vertex count and root
  logic [CB-1:0] n_eff;
  logic [VB-1:0] root_eff;
  always_comb begin
    if (vcount_q < CB'(2)) n_eff = CB'(2);
    else if (vcount_q > CB'(MV)) n_eff = CB'(MV);
    else n_eff = vcount_q;
    root_eff = ({1'b0, root_q} < n_eff) ? root_q : '0;
  end

  // load position with out-of-range recovery
  logic [CB-1:0] lrow, lcol, ncol, nrow;
  logic          last_item;
  always_comb begin
    lrow = row_q;
    lcol = col_q;
    if (row_q >= n_eff - CB'(1) || col_q >= n_eff || col_q <= row_q) begin
      lrow = '0;
      lcol = CB'(1);
    end
    ncol = lcol + CB'(1);
    nrow = lrow;
    if (ncol >= n_eff) begin
      nrow = lrow + CB'(1);
      ncol = lrow + CB'(2);
    end
    last_item = (nrow >= n_eff - CB'(1));
  end

  logic in_acc;
  assign in_i.ready = (state_q == sbst_pkg::ST_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;

  // RAM ports
  logic          w_we;
  logic [AB-1:0] w_waddr, w_raddr, pm_waddr, pm_raddr;
  logic [WB-1:0] w_rdata, pm_rdata, pm_wdata;
  logic          pm_we;

  logic [VB-1:0] pv;
  logic [VB-1:0] cur_u;
  logic [WB-1:0] pm_max;
  logic [WB-1:0] diff;

  assign pv     = parent_q[v_q];
  assign cur_u  = order_q[k_q[VB-1:0]];
  assign diff   = w_rdata - pm_rdata;

  always_comb begin
    pm_max = (u_q == p_q) ? '0 : pm_rdata;
    if (w_q > pm_max) pm_max = w_q;
  end

  always_comb begin
    w_we     = in_acc;
    w_waddr  = {lrow[VB-1:0], lcol[VB-1:0]};
    w_raddr  = '0;
    pm_raddr = '0;
    pm_we    = (state_q == sbst_pkg::ST_PM_WR);
    pm_waddr = sbst_pkg::pair_addr(u_q, v_q);
    pm_wdata = pm_max;
    case (state_q)
      sbst_pkg::ST_JOIN:    w_raddr = sbst_pkg::pair_addr(pv, v_q);
      sbst_pkg::ST_UPD_RD:  w_raddr = sbst_pkg::pair_addr(v_q, idx_q[VB-1:0]);
      sbst_pkg::ST_PM_RD:   pm_raddr = sbst_pkg::pair_addr(cur_u, p_q);
      sbst_pkg::ST_PAIR_RD: begin
        w_raddr  = sbst_pkg::pair_addr(i_q[VB-1:0], j_q[VB-1:0]);
        pm_raddr = sbst_pkg::pair_addr(i_q[VB-1:0], j_q[VB-1:0]);
      end
      default: ;
    endcase
  end

  sbst_ram #(.Width(WB), .Depth(sbst_pkg::MemDepth)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (in_i.edge_weight),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  sbst_ram #(.Width(WB), .Depth(sbst_pkg::MemDepth)) u_pathmax_ram (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (pm_waddr),
    .wdata_i (pm_wdata),
    .raddr_i (pm_raddr),
    .rdata_o (pm_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbst_pkg::ST_LOAD:    if (in_acc && last_item) state_d = sbst_pkg::ST_INIT;
      sbst_pkg::ST_INIT:    state_d = sbst_pkg::ST_SEL;
      sbst_pkg::ST_SEL:     if (idx_q == n_eff - CB'(1)) state_d = sbst_pkg::ST_JOIN;
      sbst_pkg::ST_JOIN:    state_d = (pv != v_q) ? sbst_pkg::ST_JWAIT : sbst_pkg::ST_UPD_RD;
      sbst_pkg::ST_JWAIT:   state_d = sbst_pkg::ST_PM_RD;
      sbst_pkg::ST_PM_RD:   state_d = (k_q == joined_q) ? sbst_pkg::ST_UPD_RD
                                                        : sbst_pkg::ST_PM_WR;
      sbst_pkg::ST_PM_WR:   state_d = sbst_pkg::ST_PM_RD;
      sbst_pkg::ST_UPD_RD: begin
        if (idx_q == n_eff) begin
          state_d = (joined_q == n_eff) ? sbst_pkg::ST_PAIR_ROW : sbst_pkg::ST_SEL;
        end else begin
          state_d = sbst_pkg::ST_UPD_CMP;
        end
      end
      sbst_pkg::ST_UPD_CMP:  state_d = sbst_pkg::ST_UPD_RD;
      sbst_pkg::ST_PAIR_ROW: state_d = (i_q == n_eff - CB'(1)) ? sbst_pkg::ST_FINISH
                                                                : sbst_pkg::ST_PAIR_RD;
      sbst_pkg::ST_PAIR_RD:  state_d = (j_q == n_eff) ? sbst_pkg::ST_PAIR_ROW
                                                      : sbst_pkg::ST_PAIR_CMP;
      sbst_pkg::ST_PAIR_CMP: state_d = sbst_pkg::ST_PAIR_RD;
      sbst_pkg::ST_FINISH:   if (!out_valid_q || out_o.ready) state_d = sbst_pkg::ST_LOAD;
      default:               state_d = sbst_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbst_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration and load position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= CB'(2);
      root_q   <= '0;
      row_q    <= '0;
      col_q    <= CB'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == sbst_pkg::CfgVertexCount) vcount_q <= cfg_data_i[CB-1:0];
      if (cfg_idx_i == sbst_pkg::CfgRootVertex)  root_q   <= cfg_data_i[VB-1:0];
      row_q <= '0;
      col_q <= CB'(1);
    end else if (in_acc) begin
      if (last_item) begin
        row_q <= '0;
        col_q <= CB'(1);
      end else begin
        row_q <= nrow;
        col_q <= ncol;
      end
    end
  end

  // tree membership
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tree_q <= '0;
    end else if (state_q == sbst_pkg::ST_INIT) begin
      in_tree_q <= '0;
    end else if (state_q == sbst_pkg::ST_JOIN) begin
      in_tree_q[v_q] <= 1'b1;
    end
  end

  // sequencer counters and the shared compare datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      joined_q <= '0;
      k_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      found_q  <= 1'b0;
      bfound_q <= 1'b0;
    end else begin
      case (state_q)
        sbst_pkg::ST_INIT: begin
          idx_q    <= '0;
          joined_q <= '0;
          found_q  <= 1'b0;
          bfound_q <= 1'b0;
        end
        sbst_pkg::ST_SEL: begin
          if (!in_tree_q[idx_q[VB-1:0]] &&
              (!found_q || key_q[idx_q[VB-1:0]] < bestk_q)) begin
            found_q <= 1'b1;
          end
          idx_q <= (idx_q == n_eff - CB'(1)) ? '0 : idx_q + CB'(1);
        end
        sbst_pkg::ST_JOIN: begin
          found_q <= 1'b0;
          k_q     <= '0;
          idx_q   <= '0;
          if (pv == v_q) joined_q <= joined_q + CB'(1);
        end
        sbst_pkg::ST_PM_RD: begin
          if (k_q == joined_q) joined_q <= joined_q + CB'(1);
        end
        sbst_pkg::ST_PM_WR:   k_q <= k_q + CB'(1);
        sbst_pkg::ST_UPD_RD: begin
          if (idx_q == n_eff) begin
            idx_q <= '0;
            i_q   <= '0;
          end
        end
        sbst_pkg::ST_UPD_CMP: idx_q <= idx_q + CB'(1);
        sbst_pkg::ST_PAIR_ROW: j_q <= i_q + CB'(1);
        sbst_pkg::ST_PAIR_RD: if (j_q == n_eff) i_q <= i_q + CB'(1);
        sbst_pkg::ST_PAIR_CMP: begin
          if (!tree_q && (!bfound_q || diff < best_q)) bfound_q <= 1'b1;
          j_q <= j_q + CB'(1);
        end
        default: ;
      endcase
    end
  end

  // payload registers: keys, parents, order, running values
  always_ff @(posedge clk_i) begin
    case (state_q)
      sbst_pkg::ST_INIT: begin
        // root starts at key zero, every other vertex at infinity
        for (int t = 0; t < MV; t++) begin
          key_q[t]    <= (VB'(t) == root_eff) ? '0 : sbst_pkg::KeyInf;
          parent_q[t] <= VB'(t);
        end
        cost_q <= '0;
      end
      sbst_pkg::ST_SEL: begin
        if (!in_tree_q[idx_q[VB-1:0]] &&
            (!found_q || key_q[idx_q[VB-1:0]] < bestk_q)) begin
          bestk_q <= key_q[idx_q[VB-1:0]];
          v_q     <= idx_q[VB-1:0];
        end
      end
      sbst_pkg::ST_JOIN: begin
        p_q <= pv;
        if (pv == v_q) order_q[joined_q[VB-1:0]] <= v_q;
      end
      sbst_pkg::ST_JWAIT: begin
        w_q    <= w_rdata;
        cost_q <= cost_q + NB'(w_rdata);
      end
      sbst_pkg::ST_PM_RD: begin
        u_q <= cur_u;
        if (k_q == joined_q) order_q[joined_q[VB-1:0]] <= v_q;
      end
      sbst_pkg::ST_UPD_CMP: begin
        if (!in_tree_q[idx_q[VB-1:0]] && {1'b0, w_rdata} < key_q[idx_q[VB-1:0]]) begin
          key_q[idx_q[VB-1:0]]    <= {1'b0, w_rdata};
          parent_q[idx_q[VB-1:0]] <= v_q;
        end
      end
      sbst_pkg::ST_PAIR_ROW: pi_q <= parent_q[i_q[VB-1:0]];
      sbst_pkg::ST_PAIR_RD: begin
        tree_q <= (pi_q == j_q[VB-1:0]) || (parent_q[j_q[VB-1:0]] == i_q[VB-1:0]);
      end
      sbst_pkg::ST_PAIR_CMP: begin
        if (!tree_q && (!bfound_q || diff < best_q)) best_q <= diff;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == sbst_pkg::ST_FINISH && (!out_valid_q || out_o.ready)) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sbst_pkg::ST_FINISH && (!out_valid_q || out_o.ready)) begin
      out_cost_q  <= bfound_q ? cost_q + NB'(best_q) : '0;
      out_noalt_q <= !bfound_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.second_cost    = out_cost_q;
  assign out_o.no_alternative = out_noalt_q;

endmodule

@@ rtl/sbst_ram.sv @@
// ----------------------------------------------------------------------------
// sbst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
